// ===== hw/rtl/wssc_pkg.sv =====
// ----------------------------------------------------------------------------
// wssc_pkg: shared types and constants of the wiper servo sweep controller
// Holds the mode codes, register indexes, reset values and the debouncer
// control struct.
// ----------------------------------------------------------------------------
package wssc_pkg;

  // wiper mode codes, as shown on the result word
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } mode_e;

  // configuration register indexes
  localparam logic [2:0] CFG_SWEEP_LOW  = 3'd0;
  localparam logic [2:0] CFG_SWEEP_HIGH = 3'd1;
  localparam logic [2:0] CFG_SLOW_STEP  = 3'd2;
  localparam logic [2:0] CFG_FAST_STEP  = 3'd3;
  localparam logic [2:0] CFG_PERIOD     = 3'd4;
  localparam logic [2:0] CFG_END_HOLD   = 3'd5;
  localparam logic [2:0] CFG_DEBOUNCE   = 3'd6;
  localparam logic [2:0] CFG_SETTLE     = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [11:0] RST_SWEEP_LOW  = 12'd1237;
  localparam logic [11:0] RST_SWEEP_HIGH = 12'd1762;
  localparam logic [8:0]  RST_SLOW_STEP  = 9'd6;
  localparam logic [8:0]  RST_FAST_STEP  = 9'd18;
  localparam logic [9:0]  RST_PERIOD     = 10'd20;
  localparam logic [15:0] RST_END_HOLD   = 16'd80;
  localparam logic [15:0] RST_DEBOUNCE   = 16'd60;
  localparam logic [15:0] RST_SETTLE     = 16'd400;

  // servo pulse limits on the output
  localparam logic [11:0] PULSE_MIN = 12'd500;
  localparam logic [11:0] PULSE_MAX = 12'd2500;

  // per-button debouncer control
  typedef struct packed {
    logic step;   // a word is processed this cycle
    logic seed;   // first word: load raw level and time
    logic upd;    // run the debounce update for this word
  } deb_ctrl_t;

endpackage

// ===== hw/rtl/wssc_debounce.sv =====
// ----------------------------------------------------------------------------
// wssc_debounce: one button debouncer
// Accepts a raw level once it has held for the debounce time and flags a
// press edge of the accepted level.
// ----------------------------------------------------------------------------
module wssc_debounce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wssc_pkg::deb_ctrl_t ctrl_i,
  input  logic                raw_i,
  input  logic [31:0]         now_i,
  input  logic [15:0]         debounce_ms_i,
  output logic                press_o
);

  logic        stable_q, stable_d;
  logic        last_q, last_d;
  logic [31:0] chg_q, chg_d;

  logic        base_stable, base_last;
  logic [31:0] base_chg;
  logic [31:0] upd_chg;
  logic [31:0] elapsed;
  logic        upd_stable;

  // seeding overrides the stored state on the first word
  always_comb begin
    base_stable = ctrl_i.seed ? raw_i : stable_q;
    base_last   = ctrl_i.seed ? raw_i : last_q;
    base_chg    = ctrl_i.seed ? now_i : chg_q;
  end

  // debounce update
  always_comb begin
    upd_chg    = (raw_i != base_last) ? now_i : base_chg;
    elapsed    = now_i - upd_chg;
    upd_stable = (elapsed >= {16'd0, debounce_ms_i}) ? raw_i : base_stable;
  end

  assign press_o = ctrl_i.upd && !base_stable && upd_stable;

  // skipped updates still keep the seeded values
  always_comb begin
    if (ctrl_i.upd) begin
      stable_d = upd_stable;
      last_d   = raw_i;
      chg_d    = upd_chg;
    end else begin
      stable_d = base_stable;
      last_d   = base_last;
      chg_d    = base_chg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      last_q   <= 1'b0;
      chg_q    <= 32'd0;
    end else if (ctrl_i.step) begin
      stable_q <= stable_d;
      last_q   <= last_d;
      chg_q    <= chg_d;
    end
  end

endmodule

// ===== hw/rtl/wiper_servo_sweep_controller_core.sv =====
// ----------------------------------------------------------------------------
// wiper_servo_sweep_controller_core: wiper servo sweep controller
// Debounces three mode buttons and sweeps a servo pulse width between two
// configurable ends, one result word per time stamp word.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the result channel does not stall; input
//   register, one pass of logic, result register, so a new word is taken while
//   a finished result still waits
// reset: asynchronous, active low; stop mode, pulse parked at 1237 us,
//   pwm off, buttons unseeded, registers at their documented defaults
module wiper_servo_sweep_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [wssc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wssc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic        raw_slow_i,
  input  logic        raw_fast_i,
  input  logic        raw_stop_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pulse_us_o,
  output logic        pwm_enable_o,
  output logic [1:0]  wiper_mode_o,
  output logic        pulse_written_o
);

  // configuration registers
  logic [11:0] sweep_low_q, sweep_high_q;
  logic [8:0]  slow_step_q, fast_step_q;
  logic [9:0]  period_q;
  logic [15:0] end_hold_q, debounce_q, settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_low_q  <= wssc_pkg::RST_SWEEP_LOW;
      sweep_high_q <= wssc_pkg::RST_SWEEP_HIGH;
      slow_step_q  <= wssc_pkg::RST_SLOW_STEP;
      fast_step_q  <= wssc_pkg::RST_FAST_STEP;
      period_q     <= wssc_pkg::RST_PERIOD;
      end_hold_q   <= wssc_pkg::RST_END_HOLD;
      debounce_q   <= wssc_pkg::RST_DEBOUNCE;
      settle_q     <= wssc_pkg::RST_SETTLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wssc_pkg::CFG_SWEEP_LOW:  sweep_low_q  <= cfg_wdata_i[11:0];
        wssc_pkg::CFG_SWEEP_HIGH: sweep_high_q <= cfg_wdata_i[11:0];
        wssc_pkg::CFG_SLOW_STEP:  slow_step_q  <= cfg_wdata_i[8:0];
        wssc_pkg::CFG_FAST_STEP:  fast_step_q  <= cfg_wdata_i[8:0];
        wssc_pkg::CFG_PERIOD:     period_q     <= cfg_wdata_i[9:0];
        wssc_pkg::CFG_END_HOLD:   end_hold_q   <= cfg_wdata_i;
        wssc_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        wssc_pkg::CFG_SETTLE:     settle_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic        in_valid_q;
  logic [31:0] now_q;
  logic        raw_slow_q, raw_fast_q, raw_stop_q;
  logic        advance;

  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      now_q      <= now_ms_i;
      raw_slow_q <= raw_slow_i;
      raw_fast_q <= raw_fast_i;
      raw_stop_q <= raw_stop_i;
    end
  end

  // button debouncers, stop has priority over fast over slow
  logic                seeded_q;
  logic                press_stop, press_fast, press_slow;
  wssc_pkg::deb_ctrl_t ctrl_stop, ctrl_fast, ctrl_slow;

  always_comb begin
    ctrl_stop = '{step: advance, seed: !seeded_q, upd: 1'b1};
    ctrl_fast = '{step: advance, seed: !seeded_q, upd: !press_stop};
    ctrl_slow = '{step: advance, seed: !seeded_q, upd: !press_stop && !press_fast};
  end

  wssc_debounce u_deb_stop (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_stop),
    .raw_i         (raw_stop_q),
    .now_i         (now_q),
    .debounce_ms_i (debounce_q),
    .press_o       (press_stop)
  );

  wssc_debounce u_deb_fast (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_fast),
    .raw_i         (raw_fast_q),
    .now_i         (now_q),
    .debounce_ms_i (debounce_q),
    .press_o       (press_fast)
  );

  wssc_debounce u_deb_slow (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_slow),
    .raw_i         (raw_slow_q),
    .now_i         (now_q),
    .debounce_ms_i (debounce_q),
    .press_o       (press_slow)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (advance) begin
      seeded_q <= 1'b1;
    end
  end

  // sweep state
  wssc_pkg::mode_e mode_q, mode_d;
  logic [11:0]     pulse_q, pulse_d;
  logic            dir_down_q, dir_down_d;
  logic [31:0]     last_step_q, last_step_d;
  logic [31:0]     hold_until_q, hold_until_d;
  logic            stop_pend_q, stop_pend_d;
  logic [31:0]     stop_time_q, stop_time_d;
  logic            pwm_q, pwm_d;
  logic            wrote;

  logic            sel;
  wssc_pkg::mode_e sel_mode;
  logic [8:0]      step;
  logic [13:0]     next_pulse;
  logic [31:0]     since_step, since_stop;
  logic            do_step;

  // mode select
  always_comb begin
    sel      = press_stop || press_fast || press_slow;
    sel_mode = press_stop ? wssc_pkg::MODE_STOP :
               press_fast ? wssc_pkg::MODE_FAST : wssc_pkg::MODE_SLOW;
  end

  // mode change, then settle timer or sweep step
  always_comb begin
    mode_d       = mode_q;
    pulse_d      = pulse_q;
    dir_down_d   = dir_down_q;
    last_step_d  = last_step_q;
    hold_until_d = hold_until_q;
    stop_pend_d  = stop_pend_q;
    stop_time_d  = stop_time_q;
    pwm_d        = pwm_q;
    wrote        = 1'b0;

    if (sel) begin
      mode_d       = sel_mode;
      last_step_d  = now_q;
      hold_until_d = 32'd0;
      pwm_d        = 1'b1;
      dir_down_d   = 1'b0;
      wrote        = 1'b1;
      if (sel_mode == wssc_pkg::MODE_STOP) begin
        pulse_d     = sweep_low_q;
        stop_pend_d = 1'b1;
        stop_time_d = now_q;
      end else begin
        stop_pend_d = 1'b0;
        if (pulse_q < sweep_low_q || pulse_q > sweep_high_q) begin
          pulse_d = sweep_low_q;
        end
      end
    end

    since_stop = now_q - stop_time_d;
    since_step = now_q - last_step_d;
    do_step    = (now_q >= hold_until_d) && (since_step >= {22'd0, period_q});
    step       = (mode_d == wssc_pkg::MODE_FAST) ? fast_step_q : slow_step_q;
    next_pulse = dir_down_d ? ({2'b00, pulse_d} - {5'd0, step})
                            : ({2'b00, pulse_d} + {5'd0, step});

    if (mode_d == wssc_pkg::MODE_STOP) begin
      if (stop_pend_d && pwm_d && since_stop >= {16'd0, settle_q}) begin
        pwm_d       = 1'b0;
        stop_pend_d = 1'b0;
      end
    end else begin
      pwm_d = 1'b1;
      if (do_step) begin
        last_step_d = now_q;
        wrote       = 1'b1;
        if ($signed(next_pulse) >= $signed({2'b00, sweep_high_q})) begin
          pulse_d      = sweep_high_q;
          dir_down_d   = 1'b1;
          hold_until_d = now_q + {16'd0, end_hold_q};
        end else if ($signed(next_pulse) <= $signed({2'b00, sweep_low_q})) begin
          pulse_d      = sweep_low_q;
          dir_down_d   = 1'b0;
          hold_until_d = now_q + {16'd0, end_hold_q};
        end else begin
          pulse_d = next_pulse[11:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= wssc_pkg::MODE_STOP;
      pulse_q      <= wssc_pkg::RST_SWEEP_LOW;
      dir_down_q   <= 1'b0;
      last_step_q  <= 32'd0;
      hold_until_q <= 32'd0;
      stop_pend_q  <= 1'b0;
      stop_time_q  <= 32'd0;
      pwm_q        <= 1'b0;
    end else if (advance) begin
      mode_q       <= mode_d;
      pulse_q      <= pulse_d;
      dir_down_q   <= dir_down_d;
      last_step_q  <= last_step_d;
      hold_until_q <= hold_until_d;
      stop_pend_q  <= stop_pend_d;
      stop_time_q  <= stop_time_d;
      pwm_q        <= pwm_d;
    end
  end

  // result register, pulse clamped to the servo range
  logic [11:0] clamped;

  always_comb begin
    if (pulse_d < wssc_pkg::PULSE_MIN) begin
      clamped = wssc_pkg::PULSE_MIN;
    end else if (pulse_d > wssc_pkg::PULSE_MAX) begin
      clamped = wssc_pkg::PULSE_MAX;
    end else begin
      clamped = pulse_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pulse_us_o      <= clamped;
      pwm_enable_o    <= pwm_d;
      wiper_mode_o    <= mode_d;
      pulse_written_o <= wrote;
    end
  end

endmodule

// ===== hw/rtl/wssc_checker.sv =====
// ----------------------------------------------------------------------------
// wssc_checker: port checks of the wiper servo sweep controller
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module wssc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] pulse_us_o,
  input logic        pwm_enable_o,
  input logic [1:0]  wiper_mode_o
);

  // a stalled word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled pulse holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pulse_us_o))
    else $error("stalled pulse width changed");

  // pulse stays inside the servo range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pulse_us_o >= wssc_pkg::PULSE_MIN && pulse_us_o <= wssc_pkg::PULSE_MAX)
    else $error("pulse width out of range");

  // pwm is only ever off in stop mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pwm_enable_o |-> wiper_mode_o == wssc_pkg::MODE_STOP)
    else $error("pwm off outside stop mode");

endmodule

bind wiper_servo_sweep_controller_core wssc_checker u_wssc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pulse_us_o   (pulse_us_o),
  .pwm_enable_o (pwm_enable_o),
  .wiper_mode_o (wiper_mode_o)
);

// ===== tb/tb_wiper_servo_sweep_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_wiper_servo_sweep_controller_core: self-checking bench for the sweep core
// Sends time stamp words with button levels through the valid/stall input,
// predicts every result word from its own model of debounce, mode select and
// sweep, and checks each result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_wiper_servo_sweep_controller_core;

  localparam int WORDS_PER_PHASE = 225;
  localparam int LONG_HOLD       = 120;   // receiver hold-off, in cycles
  localparam int BTN_SLOW        = 0;
  localparam int BTN_FAST        = 1;
  localparam int BTN_STOP        = 2;

  // register sets used by the random phases
  typedef enum int {
    SET_TYPICAL,
    SET_MIN,
    SET_MAX,
    SET_WIDE,
    SET_CROSSED
  } cfg_set_e;

  typedef struct packed {
    logic [11:0]     pulse;
    logic            pwm;
    wssc_pkg::mode_e mode;
    logic            written;
  } wiper_out_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [wssc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [wssc_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [31:0]                   now_ms_i;
  logic                          raw_slow_i;
  logic                          raw_fast_i;
  logic                          raw_stop_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [11:0]                   pulse_us_o;
  logic                          pwm_enable_o;
  logic [1:0]                    wiper_mode_o;
  logic                          pulse_written_o;

  wiper_servo_sweep_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .raw_slow_i     (raw_slow_i),
    .raw_fast_i     (raw_fast_i),
    .raw_stop_i     (raw_stop_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pulse_us_o     (pulse_us_o),
    .pwm_enable_o   (pwm_enable_o),
    .wiper_mode_o   (wiper_mode_o),
    .pulse_written_o(pulse_written_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // shadow copy of the registers
  logic [11:0] cfg_low, cfg_high;
  logic [8:0]  cfg_slow_step, cfg_fast_step;
  logic [9:0]  cfg_period;
  logic [15:0] cfg_end_hold, cfg_debounce, cfg_settle;

  // shadow copy of the controller state
  wssc_pkg::mode_e st_mode;
  logic [11:0]     st_pulse;
  logic            st_dir_down;
  logic [31:0]     st_last_step, st_hold_until, st_stop_time;
  logic            st_stop_pending, st_pwm_on, st_seeded, st_wrote;
  logic            btn_stable [3];
  logic            btn_raw    [3];
  logic [31:0]     btn_t      [3];

  wiper_out_t  pending_results[$];
  int          mismatches;
  int          burst_left;
  bit          long_hold_req;

  // ---------------------------------------------------------------------------
  // sweep controller model
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    cfg_low       = wssc_pkg::RST_SWEEP_LOW;
    cfg_high      = wssc_pkg::RST_SWEEP_HIGH;
    cfg_slow_step = wssc_pkg::RST_SLOW_STEP;
    cfg_fast_step = wssc_pkg::RST_FAST_STEP;
    cfg_period    = wssc_pkg::RST_PERIOD;
    cfg_end_hold  = wssc_pkg::RST_END_HOLD;
    cfg_debounce  = wssc_pkg::RST_DEBOUNCE;
    cfg_settle    = wssc_pkg::RST_SETTLE;
    st_mode         = wssc_pkg::MODE_STOP;
    st_pulse        = wssc_pkg::RST_SWEEP_LOW;
    st_dir_down     = 1'b0;
    st_last_step    = '0;
    st_hold_until   = '0;
    st_stop_time    = '0;
    st_stop_pending = 1'b0;
    st_pwm_on       = 1'b0;
    st_seeded       = 1'b0;
    st_wrote        = 1'b0;
    for (int b = 0; b < 3; b++) begin
      btn_stable[b] = 1'b0;
      btn_raw[b]    = 1'b0;
      btn_t[b]      = '0;
    end
  endfunction

  // debounce one button, report a released-to-pressed change of its stable level
  function automatic logic button_pressed(input int b, input logic raw, input logic [31:0] t);
    logic        prev;
    logic [31:0] held;
    prev = btn_stable[b];
    if (raw != btn_raw[b]) begin
      btn_raw[b] = raw;
      btn_t[b]   = t;
    end
    held = t - btn_t[b];
    if (held >= 32'(cfg_debounce)) btn_stable[b] = btn_raw[b];
    return !prev && btn_stable[b];
  endfunction

  function automatic void enter_mode(input wssc_pkg::mode_e m, input logic [31:0] t);
    st_mode       = m;
    st_last_step  = t;
    st_hold_until = '0;
    st_pwm_on     = 1'b1;
    st_dir_down   = 1'b0;
    st_wrote      = 1'b1;
    if (m == wssc_pkg::MODE_STOP) begin
      st_pulse        = cfg_low;
      st_stop_pending = 1'b1;
      st_stop_time    = t;
    end else begin
      st_stop_pending = 1'b0;
      if (st_pulse < cfg_low || st_pulse > cfg_high) st_pulse = cfg_low;
    end
  endfunction

  function automatic void sweep_tick(input logic [31:0] t);
    logic [31:0] since;
    int          step;
    int          nxt;
    // stop mode: switch pwm off once the settle time has passed
    if (st_mode == wssc_pkg::MODE_STOP) begin
      since = t - st_stop_time;
      if (st_stop_pending && st_pwm_on && since >= 32'(cfg_settle)) begin
        st_pwm_on       = 1'b0;
        st_stop_pending = 1'b0;
      end
      return;
    end
    st_pwm_on = 1'b1;
    // plain unsigned compare, no wrap handling
    if (t < st_hold_until) return;
    since = t - st_last_step;
    if (since < 32'(cfg_period)) return;
    st_last_step = t;
    step = (st_mode == wssc_pkg::MODE_FAST) ? int'(cfg_fast_step) : int'(cfg_slow_step);
    nxt  = st_dir_down ? int'(st_pulse) - step : int'(st_pulse) + step;
    // upper end is tested first
    if (nxt >= int'(cfg_high)) begin
      nxt           = int'(cfg_high);
      st_dir_down   = 1'b1;
      st_hold_until = t + 32'(cfg_end_hold);
    end else if (nxt <= int'(cfg_low)) begin
      nxt           = int'(cfg_low);
      st_dir_down   = 1'b0;
      st_hold_until = t + 32'(cfg_end_hold);
    end
    st_pulse = 12'(nxt);
    st_wrote = 1'b1;
  endfunction

  // raw is {stop, fast, slow}
  function automatic wiper_out_t wiper_next_result(input logic [31:0] t, input logic [2:0] raw);
    wiper_out_t  r;
    logic [11:0] p;
    st_wrote = 1'b0;
    if (!st_seeded) begin
      for (int b = 0; b < 3; b++) begin
        btn_stable[b] = raw[b];
        btn_raw[b]    = raw[b];
        btn_t[b]      = t;
      end
      st_seeded = 1'b1;
    end
    // stop wins, a firing button keeps the lower ones from updating
    if (button_pressed(BTN_STOP, raw[BTN_STOP], t)) enter_mode(wssc_pkg::MODE_STOP, t);
    else if (button_pressed(BTN_FAST, raw[BTN_FAST], t)) enter_mode(wssc_pkg::MODE_FAST, t);
    else if (button_pressed(BTN_SLOW, raw[BTN_SLOW], t)) enter_mode(wssc_pkg::MODE_SLOW, t);
    sweep_tick(t);
    p = st_pulse;
    if (p < wssc_pkg::PULSE_MIN) p = wssc_pkg::PULSE_MIN;
    if (p > wssc_pkg::PULSE_MAX) p = wssc_pkg::PULSE_MAX;
    r.pulse   = p;
    r.pwm     = st_pwm_on;
    r.mode    = st_mode;
    r.written = st_wrote;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one word and wait until it is taken
  task automatic send_word(input logic [31:0] t, input logic s, input logic f,
                           input logic p);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    now_ms_i   <= t;
    raw_slow_i <= s;
    raw_fast_i <= f;
    raw_stop_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(wiper_next_result(t, {p, f, s}));
  endtask

  // send in bursts with random gaps in between
  task automatic issue_word(input logic [31:0] t, input logic s, input logic f,
                            input logic p);
    int gap;
    send_word(t, s, f, p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // drop valid and wait for every result word to come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 16'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      wssc_pkg::CFG_SWEEP_LOW:  cfg_low       = 12'(val);
      wssc_pkg::CFG_SWEEP_HIGH: cfg_high      = 12'(val);
      wssc_pkg::CFG_SLOW_STEP:  cfg_slow_step = 9'(val);
      wssc_pkg::CFG_FAST_STEP:  cfg_fast_step = 9'(val);
      wssc_pkg::CFG_PERIOD:     cfg_period    = 10'(val);
      wssc_pkg::CFG_END_HOLD:   cfg_end_hold  = 16'(val);
      wssc_pkg::CFG_DEBOUNCE:   cfg_debounce  = 16'(val);
      wssc_pkg::CFG_SETTLE:     cfg_settle    = 16'(val);
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned lo, input int unsigned hi,
                              input int unsigned slow, input int unsigned fast,
                              input int unsigned period, input int unsigned hold,
                              input int unsigned deb, input int unsigned settle);
    write_reg(wssc_pkg::CFG_SWEEP_LOW, lo);
    write_reg(wssc_pkg::CFG_SWEEP_HIGH, hi);
    write_reg(wssc_pkg::CFG_SLOW_STEP, slow);
    write_reg(wssc_pkg::CFG_FAST_STEP, fast);
    write_reg(wssc_pkg::CFG_PERIOD, period);
    write_reg(wssc_pkg::CFG_END_HOLD, hold);
    write_reg(wssc_pkg::CFG_DEBOUNCE, deb);
    write_reg(wssc_pkg::CFG_SETTLE, settle);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern in stretches, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int run;
    int pct;
    int held;
    out_stall_i = 1'b0;
    forever begin
      run = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (run) begin
        @(negedge clk_i);
        if (long_hold_req) begin
          out_stall_i <= 1'b1;
          held = 0;
          while (held < LONG_HOLD) begin
            @(negedge clk_i);
            held++;
          end
          long_hold_req = 1'b0;
        end
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    wiper_out_t got;
    wiper_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.pulse   = pulse_us_o;
      got.pwm     = pwm_enable_o;
      got.mode    = wssc_pkg::mode_e'(wiper_mode_o);
      got.written = pulse_written_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: pulse %0d pwm %0b mode %0d written %0b",
                   got.pulse, got.pwm, got.mode, got.written);
      end else begin
        want = pending_results.pop_front();
        if (got.pulse !== want.pulse || got.pwm !== want.pwm ||
            got.mode !== want.mode || got.written !== want.written) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected pulse %0d pwm %0b mode %0d written %0b,",
                      " got pulse %0d pwm %0b mode %0d written %0b"},
                     want.pulse, want.pwm, want.mode, want.written,
                     got.pulse, got.pwm, got.mode, got.written);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // seeding, debounce across the time wrap, every mode, settle, period zero,
  // low above high, hold end wrapping, extreme registers and output clamp
  task automatic test_directed_cases();
    // defaults: first word seeds with all buttons held, no edge
    issue_word(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1);
    issue_word(32'h0000_0010, 1'b0, 1'b0, 1'b0);
    issue_word(32'h0000_0060, 1'b0, 1'b0, 1'b0);
    issue_word(32'h0000_0070, 1'b0, 1'b1, 1'b0);
    issue_word(32'h0000_00B0, 1'b0, 1'b1, 1'b0);
    issue_word(32'h0000_00C4, 1'b0, 1'b1, 1'b0);
    issue_word(32'h0000_00C4, 1'b1, 1'b1, 1'b0);
    // slow settles while stop is still bouncing in
    issue_word(32'h0000_0104, 1'b1, 1'b1, 1'b1);
    issue_word(32'h0000_0144, 1'b1, 1'b1, 1'b1);
    issue_word(32'h0000_02D4, 1'b0, 1'b0, 1'b1);
    wait_idle();

    // zero period and zero debounce; slow and stop are already stable, so no mode is set
    program_regs(2000, 2010, 500, 18, 0, 0, 0, 0);
    issue_word(32'h0000_0300, 1'b1, 1'b0, 1'b1);
    issue_word(32'h0000_0300, 1'b1, 1'b0, 1'b1);
    wait_idle();

    // low above high, longest end hold, hold end wraps past zero
    program_regs(2400, 600, 6, 1, 1, 65535, 0, 400);
    issue_word(32'h0000_0400, 1'b1, 1'b1, 1'b0);
    issue_word(32'h0000_0401, 1'b1, 1'b1, 1'b0);
    issue_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    issue_word(32'h0000_0000, 1'b1, 1'b1, 1'b0);
    wait_idle();

    // park below the pulse limit and sweep up from there, longest debounce and settle
    program_regs(100, 4000, 500, 500, 1, 0, 65535, 65535);
    issue_word(32'h0000_1000, 1'b1, 1'b0, 1'b1);
    issue_word(32'h0001_1000, 1'b1, 1'b0, 1'b1);
    issue_word(32'h0002_0000, 1'b0, 1'b0, 1'b0);
    issue_word(32'h0003_0000, 1'b0, 1'b0, 1'b0);
    issue_word(32'h0003_0001, 1'b1, 1'b0, 1'b0);
    issue_word(32'h0004_0000, 1'b1, 1'b0, 1'b0);
    for (int k = 1; k <= 4; k++) issue_word(32'h0004_0000 + 32'(k), 1'b1, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic pick_config(input cfg_set_e set);
    int unsigned lo;
    int unsigned hi;
    case (set)
      SET_MIN: program_regs(500, 500, 1, 1, 1, 0, 0, 0);
      SET_MAX: program_regs(2500, 2500, 500, 500, 1000, 65535, 65535, 65535);
      SET_WIDE: program_regs($urandom_range(0, 499), $urandom_range(2501, 4095),
                             $urandom_range(100, 500), $urandom_range(100, 500),
                             $urandom_range(0, 20), $urandom_range(0, 50),
                             $urandom_range(0, 50), $urandom_range(0, 200));
      SET_CROSSED: program_regs($urandom_range(1500, 2500), $urandom_range(500, 1499),
                                $urandom_range(1, 500), $urandom_range(1, 500),
                                $urandom_range(0, 30), $urandom_range(0, 100),
                                $urandom_range(0, 80), $urandom_range(0, 300));
      default: begin
        lo = $urandom_range(500, 2000);
        hi = lo + $urandom_range(0, 600);
        if (hi > 2500) hi = 2500;
        program_regs(lo, hi, $urandom_range(20, 500), $urandom_range(20, 500),
                     $urandom_range(0, 30), $urandom_range(0, 120),
                     $urandom_range(0, 80), $urandom_range(0, 400));
      end
    endcase
  endtask

  // button hold sequences over a moving time stamp, with bounces and noise
  task automatic run_button_traffic(input int n, input logic [31:0] start);
    logic [31:0] t;
    logic [2:0]  held;
    logic [2:0]  lv;
    int          span;
    int          pick;
    t    = start;
    held = 3'b000;
    span = (int'(cfg_debounce) + int'(cfg_period)) / 3 + 3;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // noise: any time, any levels
        lv = 3'($urandom);
        issue_word($urandom, lv[0], lv[1], lv[2]);
      end else begin
        if (pick < 9) t = t + 32'($urandom_range(0, span * 40));
        else          t = t + 32'($urandom_range(0, span));
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 5))
            0:       held = 3'b000;
            1:       held = 3'b001;
            2:       held = 3'b010;
            3:       held = 3'b100;
            default: held = 3'($urandom);
          endcase
        end
        lv = held;
        if ($urandom_range(0, 19) == 0) lv[$urandom_range(0, 2)] ^= 1'b1;
        issue_word(t, lv[BTN_SLOW], lv[BTN_FAST], lv[BTN_STOP]);
      end
    end
  endtask

  task automatic test_random_sweeps();
    cfg_set_e    plan [8];
    logic [31:0] start;
    plan = '{SET_TYPICAL, SET_MIN, SET_TYPICAL, SET_MAX,
             SET_WIDE, SET_TYPICAL, SET_CROSSED, SET_TYPICAL};
    for (int ph = 0; ph < 8; ph++) begin
      pick_config(plan[ph]);
      start = (ph == 2) ? 32'hFFFF_F000 + 32'($urandom_range(0, 4095)) : $urandom;
      run_button_traffic(WORDS_PER_PHASE, start);
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    logic [31:0] t;
    pick_config(SET_TYPICAL);
    t = $urandom;
    long_hold_req = 1'b1;
    for (int k = 0; k < 60; k++) begin
      t = t + 32'($urandom_range(0, 40));
      send_word(t, k[3], k[4], (k % 23) == 5);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    now_ms_i      = '0;
    raw_slow_i    = 1'b0;
    raw_fast_i    = 1'b0;
    raw_stop_i    = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_sweeps();
    test_output_backpressure();
    wait_idle();

    if (mismatches == 0) $display("tb_wiper_servo_sweep_controller_core: done, clean");
    else $display("tb_wiper_servo_sweep_controller_core: done, errors");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2000000;
    $display("tb_wiper_servo_sweep_controller_core: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wssc_pkg.sv
hw/rtl/wssc_debounce.sv
hw/rtl/wiper_servo_sweep_controller_core.sv
hw/rtl/wssc_checker.sv
tb/tb_wiper_servo_sweep_controller_core.sv
